// File: rtl/lted_pkg.sv
// ---------------------------------------------------------------------------
// lted_pkg
// Shared types, byte codes and result codes for the line editing discipline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lted_pkg;

    // default edit line width in characters
    localparam int LINE_WIDTH_DEF = 40;

    // field widths
    localparam int ACT_W  = 3;
    localparam int CHAR_W = 7;
    localparam int CNT_W  = 6;
    localparam int BYTE_W = 8;

    // largest erase count the result field can carry
    localparam int CNT_MAX = 63;

    // configuration register indexes
    localparam logic CFG_ERASE = 1'b0;
    localparam logic CFG_KILL  = 1'b1;

    // configuration reset values
    localparam logic [BYTE_W-1:0] ERASE_RST = 8'd127;
    localparam logic [BYTE_W-1:0] KILL_RST  = 8'd21;

    // special input bytes
    localparam logic [BYTE_W-1:0] BYTE_CTRL_W = 8'h17;
    localparam logic [BYTE_W-1:0] BYTE_CTRL_D = 8'h04;
    localparam logic [BYTE_W-1:0] BYTE_ESC    = 8'h1B;
    localparam logic [BYTE_W-1:0] BYTE_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_TILDE  = 8'h7E;
    localparam logic [BYTE_W-1:0] BYTE_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] BYTE_UP_A   = 8'h41;
    localparam logic [BYTE_W-1:0] BYTE_UP_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] BYTE_LO_A   = 8'h61;
    localparam logic [BYTE_W-1:0] BYTE_LO_Z   = 8'h7A;

    // space as stored in the line memory
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

    // result action codes
    localparam logic [ACT_W-1:0] ACT_ECHO    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ERASE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BELL    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NEWLINE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_END     = 3'd5;

    // one result beat
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CHAR_W-1:0] out_char;
        logic [CNT_W-1:0]  erase_count;
        logic              last;
    } beat_t;

    // build a beat, zeroing the fields the action does not use
    function automatic beat_t mk_beat(
        input logic [ACT_W-1:0]  act,
        input logic [CHAR_W-1:0] ch,
        input logic [CNT_W-1:0]  cnt,
        input logic              lst
    );
        beat_t b;
        b.action      = act;
        b.out_char    = (act == ACT_ECHO) ? ch : '0;
        b.erase_count = (act == ACT_ERASE) ? cnt : '0;
        b.last        = lst;
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lted_ram.sv
// ---------------------------------------------------------------------------
// lted_ram
// Generic simple dual port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lted_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/lted_out.sv
// ---------------------------------------------------------------------------
// lted_out
// Output register stage holding one result beat until the sink takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lted_out (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire lted_pkg::beat_t beat_in,
    input  wire logic            out_stall,
    output logic                 out_valid,
    output lted_pkg::beat_t      beat_out,
    output logic                 free
);

    logic            valid_reg;
    logic            valid_next;
    lted_pkg::beat_t beat_reg;

    // stage can take a new beat when empty or draining this cycle
    assign free       = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                beat_reg <= beat_in;
            end
        end
    end

    assign out_valid = valid_reg;
    assign beat_out  = beat_reg;

endmodule

`default_nettype wire

// File: rtl/line_editing_terminal_discipline_unit.sv
// A simple byte's single beat passes through the pending beat register and then
// the output stage. Word erase scans the line back one character at a time.
// Word wrap scans back for the last space and then moves and echoes the word
// one character at a time.
// One byte is in work at a time; the line memory loop sets the pace.
// Reset clears control state; the line memory is not cleared (unread until written).
// ---------------------------------------------------------------------------
// line_editing_terminal_discipline_unit
// Canonical tty line editor with erase, kill, word erase and word wrap.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_editing_terminal_discipline_unit #(
    parameter int LINE_WIDTH = lted_pkg::LINE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [lted_pkg::BYTE_W-1:0]   in_byte,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [lted_pkg::ACT_W-1:0]    action,
    output logic      [lted_pkg::CHAR_W-1:0]   out_char,
    output logic      [lted_pkg::CNT_W-1:0]    erase_count,
    output logic                               last,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [lted_pkg::BYTE_W-1:0]   cfg_data
);

    localparam int LEN_W = $clog2(LINE_WIDTH + 1);
    localparam int AW    = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
    localparam logic [LEN_W-1:0] LW_LEN = LEN_W'(LINE_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_CW_RD,
        S_CW_CHK,
        S_WR_RD,
        S_WR_CHK,
        S_WR_NL,
        S_MV_RD,
        S_MV_WR,
        S_WR_PUT
    } state_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_SEEN,
        ESC_CSI
    } esc_t;

    // saturate a line count to the erase count field
    function automatic logic [lted_pkg::CNT_W-1:0] sat_cnt(input logic [LEN_W-1:0] v);
        logic [lted_pkg::CNT_W-1:0] r;
        if (32'(v) > lted_pkg::CNT_MAX)
        begin
            r = lted_pkg::CNT_W'(lted_pkg::CNT_MAX);
        end
        else
        begin
            r = lted_pkg::CNT_W'(v);
        end
        return r;
    endfunction

    state_t                          state_reg, state_next;
    state_t                          ret_reg, ret_next;
    lted_pkg::beat_t                 pend_reg, pend_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic [LEN_W-1:0]                ptr_reg, ptr_next;
    logic [LEN_W-1:0]                wl_reg, wl_next;
    logic [LEN_W-1:0]                idx_reg, idx_next;
    logic                            word_reg, word_next;
    logic [lted_pkg::CHAR_W-1:0]     byte_reg, byte_next;
    esc_t                            esc_reg, esc_next;
    logic                            ended_reg, ended_next;
    logic [lted_pkg::BYTE_W-1:0]     erase_reg, erase_next;
    logic [lted_pkg::BYTE_W-1:0]     kill_reg, kill_next;

    logic                            accept;
    logic                            out_free;
    logic                            out_load;
    lted_pkg::beat_t                 out_beat;

    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [lted_pkg::CHAR_W-1:0]     wr_data;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic [lted_pkg::CHAR_W-1:0]     rd_data;

    logic                            is_print;
    logic                            is_final;
    logic                            rd_space;
    logic [LEN_W-1:0]                ptr_dec;
    logic [LEN_W-1:0]                mv_src;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == S_EMIT) && out_free;

    // byte classes
    assign is_print = (in_byte >= lted_pkg::BYTE_SPACE) && (in_byte <= lted_pkg::BYTE_TILDE);
    assign is_final = ((in_byte >= lted_pkg::BYTE_UP_A) && (in_byte <= lted_pkg::BYTE_UP_Z))
                   || ((in_byte >= lted_pkg::BYTE_LO_A) && (in_byte <= lted_pkg::BYTE_LO_Z))
                   || (in_byte == lted_pkg::BYTE_TILDE);
    assign rd_space = (rd_data == lted_pkg::CHAR_SPACE);
    assign ptr_dec  = ptr_reg - LEN_W'(1);
    assign mv_src   = ptr_reg + idx_reg;

    // configuration registers
    always_comb
    begin
        erase_next = erase_reg;
        kill_next  = kill_reg;
        if (cfg_we)
        begin
            if (cfg_index == lted_pkg::CFG_ERASE)
            begin
                erase_next = cfg_data;
            end
            else
            begin
                kill_next = cfg_data;
            end
        end
    end

    // line memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !ended_reg && (esc_reg == ESC_NONE) && is_print
                    && (in_byte != lted_pkg::BYTE_ESC)
                    && !((in_byte == lted_pkg::BYTE_CTRL_D) && (len_reg == '0))
                    && !((in_byte == erase_reg) && (len_reg != '0))
                    && (in_byte != kill_reg)
                    && !((in_byte == lted_pkg::BYTE_CTRL_W) && (len_reg != '0))
                    && (len_reg < LW_LEN))
                begin
                    wr_en   = 1'b1;
                    wr_addr = len_reg[AW-1:0];
                    wr_data = in_byte[lted_pkg::CHAR_W-1:0];
                end
            end
            S_CW_RD, S_WR_RD:
            begin
                rd_en   = (ptr_reg != '0);
                rd_addr = ptr_dec[AW-1:0];
            end
            S_MV_RD:
            begin
                rd_en   = (idx_reg != wl_reg);
                rd_addr = mv_src[AW-1:0];
            end
            S_MV_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                wr_data = rd_data;
            end
            S_WR_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = wl_reg[AW-1:0];
                wr_data = byte_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        pend_next  = pend_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        wl_next    = wl_reg;
        idx_next   = idx_reg;
        word_next  = word_reg;
        byte_next  = byte_reg;
        esc_next   = esc_reg;
        ended_next = ended_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !ended_reg)
                begin
                    ret_next = S_IDLE;
                    if (esc_reg == ESC_SEEN)
                    begin
                        if (in_byte == lted_pkg::BYTE_LBRACK)
                        begin
                            esc_next = ESC_CSI;
                        end
                        else
                        begin
                            esc_next   = ESC_NONE;
                            pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_BELL, '0, '0, 1'b1);
                            state_next = S_EMIT;
                        end
                    end
                    else if (esc_reg == ESC_CSI)
                    begin
                        if (is_final)
                        begin
                            esc_next   = ESC_NONE;
                            pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_BELL, '0, '0, 1'b1);
                            state_next = S_EMIT;
                        end
                    end
                    else if (in_byte == lted_pkg::BYTE_ESC)
                    begin
                        esc_next = ESC_SEEN;
                    end
                    else if ((in_byte == lted_pkg::BYTE_CTRL_D) && (len_reg == '0))
                    begin
                        ended_next = 1'b1;
                        pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_END, '0, '0, 1'b1);
                        state_next = S_EMIT;
                    end
                    else if ((in_byte == erase_reg) && (len_reg != '0))
                    begin
                        len_next   = len_reg - LEN_W'(1);
                        pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_ERASE, '0,
                                                       lted_pkg::CNT_W'(1), 1'b1);
                        state_next = S_EMIT;
                    end
                    else if (in_byte == kill_reg)
                    begin
                        if (len_reg != '0)
                        begin
                            len_next   = '0;
                            pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_CLEAR, '0, '0, 1'b1);
                            state_next = S_EMIT;
                        end
                    end
                    else if ((in_byte == lted_pkg::BYTE_CTRL_W) && (len_reg != '0))
                    begin
                        ptr_next   = len_reg;
                        word_next  = 1'b0;
                        state_next = S_CW_RD;
                    end
                    else if (is_print)
                    begin
                        if (len_reg >= LW_LEN)
                        begin
                            if (in_byte != lted_pkg::BYTE_SPACE)
                            begin
                                ptr_next   = LW_LEN;
                                byte_next  = in_byte[lted_pkg::CHAR_W-1:0];
                                state_next = S_WR_RD;
                            end
                        end
                        else
                        begin
                            len_next   = len_reg + LEN_W'(1);
                            pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_ECHO,
                                             in_byte[lted_pkg::CHAR_W-1:0], '0, 1'b1);
                            state_next = S_EMIT;
                        end
                    end
                    else if ((in_byte != erase_reg) && (in_byte != kill_reg)
                             && (in_byte != lted_pkg::BYTE_CTRL_W)
                             && (in_byte != lted_pkg::BYTE_CTRL_D))
                    begin
                        pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_BELL, '0, '0, 1'b1);
                        state_next = S_EMIT;
                    end
                end
            end
            // hand the pending beat to the output stage
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ret_reg;
                end
            end
            // word erase: skip trailing spaces, then the word
            S_CW_RD:
            begin
                if (ptr_reg == '0)
                begin
                    pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_ERASE, '0,
                                                   sat_cnt(len_reg - ptr_reg), 1'b1);
                    len_next   = ptr_reg;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_CW_CHK;
                end
            end
            S_CW_CHK:
            begin
                if (word_reg && rd_space)
                begin
                    pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_ERASE, '0,
                                                   sat_cnt(len_reg - ptr_reg), 1'b1);
                    len_next   = ptr_reg;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    ptr_next   = ptr_dec;
                    word_next  = word_reg || !rd_space;
                    state_next = S_CW_RD;
                end
            end
            // wrap: find the last space on the full line
            S_WR_RD:
            begin
                if (ptr_reg == '0)
                begin
                    // no space at all: hard break
                    wl_next    = '0;
                    idx_next   = '0;
                    pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_NEWLINE, '0, '0, 1'b0);
                    ret_next   = S_MV_RD;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_WR_CHK;
                end
            end
            S_WR_CHK:
            begin
                if (!rd_space)
                begin
                    ptr_next   = ptr_dec;
                    state_next = S_WR_RD;
                end
                else
                begin
                    wl_next    = LW_LEN - ptr_reg;
                    idx_next   = '0;
                    state_next = S_EMIT;
                    if (ptr_reg != LW_LEN)
                    begin
                        pend_next = lted_pkg::mk_beat(lted_pkg::ACT_ERASE, '0,
                                                      sat_cnt(LW_LEN - ptr_reg), 1'b0);
                        ret_next  = S_WR_NL;
                    end
                    else
                    begin
                        pend_next = lted_pkg::mk_beat(lted_pkg::ACT_NEWLINE, '0, '0, 1'b0);
                        ret_next  = S_MV_RD;
                    end
                end
            end
            S_WR_NL:
            begin
                pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_NEWLINE, '0, '0, 1'b0);
                ret_next   = S_MV_RD;
                state_next = S_EMIT;
            end
            // move the trailing word to the front and echo it
            S_MV_RD:
            begin
                if (idx_reg == wl_reg)
                begin
                    state_next = S_WR_PUT;
                end
                else
                begin
                    state_next = S_MV_WR;
                end
            end
            S_MV_WR:
            begin
                pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_ECHO, rd_data, '0, 1'b0);
                idx_next   = idx_reg + LEN_W'(1);
                ret_next   = S_MV_RD;
                state_next = S_EMIT;
            end
            // store and echo the new character
            S_WR_PUT:
            begin
                len_next   = wl_reg + LEN_W'(1);
                pend_next  = lted_pkg::mk_beat(lted_pkg::ACT_ECHO, byte_reg, '0, 1'b1);
                ret_next   = S_IDLE;
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            pend_reg  <= '0;
            len_reg   <= '0;
            ptr_reg   <= '0;
            wl_reg    <= '0;
            idx_reg   <= '0;
            word_reg  <= 1'b0;
            byte_reg  <= '0;
            esc_reg   <= ESC_NONE;
            ended_reg <= 1'b0;
            erase_reg <= lted_pkg::ERASE_RST;
            kill_reg  <= lted_pkg::KILL_RST;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pend_reg  <= pend_next;
            len_reg   <= len_next;
            ptr_reg   <= ptr_next;
            wl_reg    <= wl_next;
            idx_reg   <= idx_next;
            word_reg  <= word_next;
            byte_reg  <= byte_next;
            esc_reg   <= esc_next;
            ended_reg <= ended_next;
            erase_reg <= erase_next;
            kill_reg  <= kill_next;
        end
    end

    // line memory
    lted_ram #(
        .WIDTH (lted_pkg::CHAR_W),
        .DEPTH (LINE_WIDTH),
        .AW    (AW)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result output register
    lted_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .beat_in   (pend_reg),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .beat_out  (out_beat),
        .free      (out_free)
    );

    assign action      = out_beat.action;
    assign out_char    = out_beat.out_char;
    assign erase_count = out_beat.erase_count;
    assign last        = out_beat.last;

endmodule

`default_nettype wire

// File: rtl/lted_checker.sv
// ---------------------------------------------------------------------------
// lted_checker
// Port level checks on the result channel of the line editing discipline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lted_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [lted_pkg::ACT_W-1:0]  action,
    input wire logic [lted_pkg::CHAR_W-1:0] out_char,
    input wire logic [lted_pkg::CNT_W-1:0]  erase_count,
    input wire logic                        last
);

    // a stalled beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action) && $stable(out_char)
                                   && $stable(erase_count) && $stable(last))
        else $error("result beat changed while stalled");

    // only echo beats carry a character
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action != lted_pkg::ACT_ECHO) |-> (out_char == '0))
        else $error("character on a non-echo beat");

    // only erase beats carry a count, and an erase beat always rubs something out
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((action == lted_pkg::ACT_ERASE) ? (erase_count != '0)
                                                       : (erase_count == '0)))
        else $error("erase count inconsistent with action");

    // single-beat actions always close their byte
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((action == lted_pkg::ACT_END) || (action == lted_pkg::ACT_CLEAR)
                      || (action == lted_pkg::ACT_BELL)) |-> last)
        else $error("end, clear or bell beat without last");

endmodule

bind line_editing_terminal_discipline_unit lted_checker u_lted_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .action      (action),
    .out_char    (out_char),
    .erase_count (erase_count),
    .last        (last)
);

`default_nettype wire

// File: tb/line_editing_terminal_discipline_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_editing_terminal_discipline_unit_tb
// Feeds keyboard bytes through the line editor and checks every display beat
// against a behavioral editor kept in the bench. Covers echo, erase, kill,
// word erase, escape swallowing, word wrap, hard break and end of session
// under several erase/kill settings, with random gaps and stalls on both
// channels and one long receiver hold-off.
// ---------------------------------------------------------------------------

module line_editing_terminal_discipline_unit_tb;

    import lted_pkg::*;

    localparam int PERIOD     = 8;
    localparam int LW         = LINE_WIDTH_DEF;
    localparam int SETTLE     = 5 * LW + 20;
    localparam int STALL_LIM  = 5000;
    localparam int NSET       = 6;
    localparam int HOLD_LEN   = 400;
    localparam int MAX_PRINTS = 30;

    // escape tracking in the bench editor
    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_OPEN,
        ESC_CSI
    } esc_phase_t;

    // full editor state, register values included
    typedef struct packed {
        logic [LW-1:0][CHAR_W-1:0] line;
        logic [7:0]                len;
        esc_phase_t                esc;
        logic                      ended;
        logic [BYTE_W-1:0]         erase_b;
        logic [BYTE_W-1:0]         kill_b;
    } editor_t;

    // opening bytes: edits, empty-line cases, high bytes and escapes
    localparam logic [BYTE_W-1:0] OPENING [24] = '{
        BYTE_SPACE, BYTE_UP_A, BYTE_TILDE, ERASE_RST,
        BYTE_CTRL_W, BYTE_CTRL_W, BYTE_CTRL_W, ERASE_RST,
        KILL_RST, 8'h78, BYTE_CTRL_D, KILL_RST,
        8'h00, 8'hFF, 8'h80, BYTE_ESC,
        8'h78, BYTE_ESC, BYTE_LBRACK, 8'h31,
        BYTE_UP_A, BYTE_ESC, BYTE_LBRACK, BYTE_TILDE
    };

    // register settings visited after the reset values
    localparam logic [BYTE_W-1:0] ERASE_SET [NSET] = '{
        8'h08, 8'h00, 8'hFF, 8'h61, 8'h17, ERASE_RST
    };
    localparam logic [BYTE_W-1:0] KILL_SET [NSET] = '{
        8'h18, 8'hFF, 8'h00, 8'h20, 8'h04, KILL_RST
    };

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    in_byte     = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b1;
    logic [ACT_W-1:0]     action;
    logic [CHAR_W-1:0]    out_char;
    logic [CNT_W-1:0]     erase_count;
    logic                 last;
    logic                 cfg_we      = 1'b0;
    logic                 cfg_index   = CFG_ERASE;
    logic [BYTE_W-1:0]    cfg_data    = '0;

    // bytes waiting to be sent and display beats still owed
    logic [BYTE_W-1:0]    keystrokes[$];
    beat_t                display_due[$];
    beat_t                step_beats[$];
    beat_t                due;

    // editor copies: live follows accepted bytes, plan follows generated ones
    editor_t              live;
    editor_t              plan;

    int                   errors      = 0;
    int                   fed_items   = 0;
    int                   bytes_taken = 0;
    int                   beats_seen  = 0;
    int                   act_seen [8];
    int                   hold_left   = 0;
    bit                   held_once   = 1'b0;
    int                   idle_cycles = 0;

    line_editing_terminal_discipline_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .action      (action),
        .out_char    (out_char),
        .erase_count (erase_count),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    // one display beat with unused fields zeroed
    function automatic beat_t disp(input logic [ACT_W-1:0] act,
                                   input logic [CHAR_W-1:0] ch, input int cnt);
        beat_t d;
        d.action      = act;
        d.out_char    = (act == ACT_ECHO) ? ch : '0;
        d.erase_count = (act == ACT_ERASE) ? CNT_W'((cnt > CNT_MAX) ? CNT_MAX : cnt) : '0;
        d.last        = 1'b0;
        return d;
    endfunction

    function automatic editor_t fresh_editor();
        editor_t e;
        e         = '0;
        e.esc     = ESC_IDLE;
        e.erase_b = ERASE_RST;
        e.kill_b  = KILL_RST;
        return e;
    endfunction

    function automatic bit ends_sequence(input logic [BYTE_W-1:0] b);
        return (b >= BYTE_UP_A && b <= BYTE_UP_Z) || (b >= BYTE_LO_A && b <= BYTE_LO_Z)
            || b == BYTE_TILDE;
    endfunction

    // apply one keyboard byte to an editor and list the display beats it causes
    function automatic void edit_step(inout editor_t st, input logic [BYTE_W-1:0] b,
                                      output beat_t res[$]);
        int p;
        int ws;
        int wl;
        res = {};
        if (st.ended)
            return;
        if (st.esc == ESC_OPEN)
        begin
            if (b == BYTE_LBRACK)
                st.esc = ESC_CSI;
            else
            begin
                st.esc = ESC_IDLE;
                res.push_back(disp(ACT_BELL, '0, 0));
            end
        end
        else if (st.esc == ESC_CSI)
        begin
            if (ends_sequence(b))
            begin
                st.esc = ESC_IDLE;
                res.push_back(disp(ACT_BELL, '0, 0));
            end
        end
        else if (b == BYTE_ESC)
            st.esc = ESC_OPEN;
        else if (b == BYTE_CTRL_D && st.len == 0)
        begin
            st.ended = 1'b1;
            res.push_back(disp(ACT_END, '0, 0));
        end
        else if (b == st.erase_b && st.len > 0)
        begin
            st.len--;
            res.push_back(disp(ACT_ERASE, '0, 1));
        end
        else if (b == st.kill_b)
        begin
            if (st.len > 0)
            begin
                st.len = 0;
                res.push_back(disp(ACT_CLEAR, '0, 0));
            end
        end
        else if (b == BYTE_CTRL_W && st.len > 0)
        begin
            // trailing spaces, then the word before them
            p = st.len;
            while (p > 0 && st.line[p-1] == CHAR_SPACE)
                p--;
            while (p > 0 && st.line[p-1] != CHAR_SPACE)
                p--;
            res.push_back(disp(ACT_ERASE, '0, st.len - p));
            st.len = p;
        end
        else if (b >= BYTE_SPACE && b <= BYTE_TILDE)
        begin
            if (st.len >= LW)
            begin
                // full line: spaces are dropped, anything else wraps or breaks
                if (b != BYTE_SPACE)
                begin
                    ws = LW;
                    while (ws > 0 && st.line[ws-1] != CHAR_SPACE)
                        ws--;
                    if (ws == 0)
                    begin
                        res.push_back(disp(ACT_NEWLINE, '0, 0));
                        st.len = 0;
                    end
                    else
                    begin
                        wl = LW - ws;
                        if (wl > 0)
                            res.push_back(disp(ACT_ERASE, '0, wl));
                        res.push_back(disp(ACT_NEWLINE, '0, 0));
                        for (int i = 0; i < wl; i++)
                            res.push_back(disp(ACT_ECHO, st.line[ws+i], 0));
                        for (int i = 0; i < wl; i++)
                            st.line[i] = st.line[ws+i];
                        st.len = wl;
                    end
                    st.line[st.len] = b[CHAR_W-1:0];
                    st.len++;
                    res.push_back(disp(ACT_ECHO, b[CHAR_W-1:0], 0));
                end
            end
            else
            begin
                st.line[st.len] = b[CHAR_W-1:0];
                st.len++;
                res.push_back(disp(ACT_ECHO, b[CHAR_W-1:0], 0));
            end
        end
        else if (b != st.erase_b && b != st.kill_b && b != BYTE_CTRL_W && b != BYTE_CTRL_D)
            res.push_back(disp(ACT_BELL, '0, 0));
        if (res.size() > 0)
            res[res.size()-1].last = 1'b1;
    endfunction

    // queue a byte unless it would end the session when that is not wanted
    function automatic void feed(input logic [BYTE_W-1:0] b, input bit may_end);
        editor_t trial;
        beat_t   res[$];
        trial = plan;
        edit_step(trial, b, res);
        if (trial.ended && !plan.ended && !may_end)
            return;
        if (!plan.ended)
            fed_items++;
        plan = trial;
        keystrokes.push_back(b);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_glyph();
        return BYTE_W'($urandom_range(8'h21, 8'h7E));
    endfunction

    function automatic logic [BYTE_W-1:0] word_char();
        if ($urandom_range(0, 3) == 0)
            return rand_glyph();
        return BYTE_W'($urandom_range(BYTE_LO_A, BYTE_LO_Z));
    endfunction

    // mostly typed words with edits and escapes, some noise
    task automatic random_burst(input int count, input bit open_long);
        int goal;
        int pick;
        goal = fed_items + count;
        if (open_long)
            repeat (LW + 1) feed(rand_glyph(), 1'b0);
        while (fed_items < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                repeat ($urandom_range(1, 9)) feed(word_char(), 1'b0);
                if ($urandom_range(0, 4) != 0)
                    feed(BYTE_SPACE, 1'b0);
            end
            else if (pick < 46)
                repeat ($urandom_range(LW + 1, LW + 4)) feed(rand_glyph(), 1'b0);
            else if (pick < 53)
                repeat ($urandom_range(1, 4)) feed(BYTE_SPACE, 1'b0);
            else if (pick < 60)
                feed(plan.erase_b, 1'b0);
            else if (pick < 63)
                feed(plan.kill_b, 1'b0);
            else if (pick < 69)
                feed(BYTE_CTRL_W, 1'b0);
            else if (pick < 78)
            begin
                feed(BYTE_ESC, 1'b0);
                if ($urandom_range(0, 9) < 3)
                    feed(BYTE_W'($urandom_range(0, 255)), 1'b0);
                else
                begin
                    feed(BYTE_LBRACK, 1'b0);
                    repeat ($urandom_range(0, 3)) feed(BYTE_W'($urandom_range(8'h30, 8'h3F)), 1'b0);
                    case ($urandom_range(0, 2))
                        0:       feed(BYTE_W'($urandom_range(BYTE_UP_A, BYTE_UP_Z)), 1'b0);
                        1:       feed(BYTE_W'($urandom_range(BYTE_LO_A, BYTE_LO_Z)), 1'b0);
                        default: feed(BYTE_TILDE, 1'b0);
                    endcase
                end
            end
            else if (pick < 88)
                feed(BYTE_W'($urandom_range(0, 255)), 1'b0);
            else if (pick < 93)
                feed(BYTE_W'($urandom_range(8'h80, 8'hFF)), 1'b0);
            else if (pick < 96)
                feed(BYTE_CTRL_D, 1'b0);
            else
                feed(BYTE_W'($urandom_range(0, 8'h1F)), 1'b0);
        end
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (keystrokes.size() != 0 || in_valid || display_due.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_reg(input logic idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_ERASE)
        begin
            live.erase_b = val;
            plan.erase_b = val;
        end
        else
        begin
            live.kill_b = val;
            plan.kill_b = val;
        end
        @(negedge clk);
    endtask

    task automatic flag(input string msg);
        if (errors < MAX_PRINTS)
            $display("mismatch at beat %0d: %s", beats_seen, msg);
        errors++;
    endtask

    // sender: offers queued bytes with random gaps, gap-free window in the middle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                edit_step(live, in_byte, step_beats);
                foreach (step_beats[i])
                    display_due.push_back(step_beats[i]);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (keystrokes.size() != 0
                    && ((bytes_taken >= 250 && bytes_taken < 350)
                        || $urandom_range(0, 99) >= 16))
                begin
                    in_byte  <= keystrokes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each beat, then picks the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                act_seen[action]++;
                if (display_due.size() == 0)
                    flag($sformatf("unexpected beat, action %0d", action));
                else
                begin
                    due = display_due.pop_front();
                    if (action !== due.action)
                        flag($sformatf("action got %0d want %0d", action, due.action));
                    if (out_char !== due.out_char)
                        flag($sformatf("out_char got %0h want %0h", out_char, due.out_char));
                    if (erase_count !== due.erase_count)
                        flag($sformatf("erase_count got %0d want %0d",
                                       erase_count, due.erase_count));
                    if (last !== due.last)
                        flag($sformatf("last got %0b want %0b", last, due.last));
                end
                beats_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!held_once && beats_seen >= 80)
            begin
                // long hold-off so the editor backs up into its input
                held_once = 1'b1;
                hold_left = HOLD_LEN - 1;
                out_stall <= 1'b1;
            end
            else if (beats_seen >= 300 && beats_seen < 500)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 16);
        end
    end

    // watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIM)
        begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIM);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus and run control
    initial
    begin
        live = fresh_editor();
        plan = live;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening, then a hard break and random typing
        foreach (OPENING[i])
            feed(OPENING[i], 1'b0);
        random_burst(60, 1'b1);

        // each register setting gets its own stretch of typing
        for (int k = 0; k < NSET; k++)
        begin
            wait_quiet();
            set_reg(CFG_ERASE, ERASE_SET[k]);
            set_reg(CFG_KILL, KILL_SET[k]);
            random_burst(70, 1'b0);
        end

        // close any escape, clear the line, end the session, then ignored bytes
        feed(8'h71, 1'b0);
        feed(8'h71, 1'b0);
        feed(plan.kill_b, 1'b0);
        feed(BYTE_CTRL_D, 1'b1);
        repeat (6) feed(BYTE_W'($urandom_range(0, 255)), 1'b0);

        wait_quiet();
        $display("covered %0d keyboard bytes across %0d register settings, %0d beats checked",
                 bytes_taken, NSET + 1, beats_seen);
        $display("beats by action: echo %0d erase %0d bell %0d newline %0d clear %0d end %0d",
                 act_seen[ACT_ECHO], act_seen[ACT_ERASE], act_seen[ACT_BELL],
                 act_seen[ACT_NEWLINE], act_seen[ACT_CLEAR], act_seen[ACT_END]);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
